// File: hw/rtl/mrw_pkg.sv
package mrw_pkg;

    // Fixed port field widths
    localparam int unsigned CAND_WIDTH    = 64;
    localparam int unsigned VERDICT_WIDTH = 2;
    localparam int unsigned S_TDATA_WIDTH = 128;
    localparam int unsigned M_TDATA_WIDTH = 8;

    // Verdict codes
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_COMPOSITE = 2'd0;
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_PROBABLE  = 2'd1;
    localparam logic [VERDICT_WIDTH-1:0] VERDICT_PRIME     = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_CLASS = 12'b0000_0000_0010,
        ST_PREP  = 12'b0000_0000_0100,
        ST_BASE  = 12'b0000_0000_1000,
        ST_ESQ   = 12'b0000_0001_0000,
        ST_EMUL  = 12'b0000_0010_0000,
        ST_ENEXT = 12'b0000_0100_0000,
        ST_XCHK  = 12'b0000_1000_0000,
        ST_SQ    = 12'b0001_0000_0000,
        ST_SCHK  = 12'b0010_0000_0000,
        ST_MUL   = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

endpackage

// File: hw/rtl/miller_rabin_witness_round.sv
// One Miller-Rabin witness round on a NUM_WIDTH-bit candidate. Each input item
// (candidate, witness) yields one verdict item: 0 composite, 1 probable prime for
// this witness, 2 prime (candidate 2 or 3). Zero, one and even candidates come
// back composite. Other odd candidates take one bit-serial pass that reduces
// the witness mod the candidate and counts the trailing zeros s of
// candidate-1, then a left-to-right exponentiation and up to s-1 squarings.
// Every modular product runs on one shared shift-and-add multiply-reduce unit
// that consumes one multiplier bit per cycle; at most about 2*NUM_WIDTH products
// are needed per item. One item is worked on at a time; a new item is taken
// while the previous verdict still waits in the output register.
module miller_rabin_witness_round
    import mrw_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // s_tdata: [63:0] candidate, [127:64] witness
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    // m_tdata: [1:0] verdict, [7:2] zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata
);

    localparam int unsigned W  = NUM_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);
    localparam logic [CW-1:0] W_C = CW'(W);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Control
    state_t                   state_reg, state_next;
    state_t                   ret_reg, ret_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [VERDICT_WIDTH-1:0] m_verdict_reg, m_verdict_next;
    logic [VERDICT_WIDTH-1:0] verdict_reg, verdict_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            s_reg, s_next;
    logic [CW-1:0]            exp_cnt_reg, exp_cnt_next;
    logic [CW-1:0]            sq_cnt_reg, sq_cnt_next;
    logic                     tz_seen_reg, tz_seen_next;
    logic                     one_reg, one_next;

    // Datapath
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] nm1_reg, nm1_next;
    logic [W-1:0] w_sr_reg, w_sr_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] tz_sr_reg, tz_sr_next;
    logic [W-1:0] exp_sr_reg, exp_sr_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] mm_a_reg, mm_a_next;
    logic [W-1:0] mm_b_reg, mm_b_next;
    logic [W-1:0] mm_acc_reg, mm_acc_next;

    // Witness reduction step: rem = (2*rem + bit) mod n
    logic [W:0] red_t, red_n, red_diff;
    logic [W-1:0] red_val;

    // Multiply-reduce step: acc = (2*acc + bit*a) mod n, input below 3n
    logic [W+1:0] mm_t, mm_n1, mm_n2, mm_d1, mm_d2, mm_sel;
    logic [W-1:0] mm_val;

    logic x_is_one, x_is_nm1;

    assign red_t    = {rem_reg, w_sr_reg[W-1]};
    assign red_n    = {1'b0, n_reg};
    assign red_diff = red_t - red_n;
    assign red_val  = (red_t >= red_n) ? red_diff[W-1:0] : red_t[W-1:0];

    assign mm_n1  = {2'b00, n_reg};
    assign mm_n2  = {1'b0, n_reg, 1'b0};
    assign mm_t   = {1'b0, mm_acc_reg, 1'b0} + (mm_b_reg[W-1] ? {2'b00, mm_a_reg} : '0);
    assign mm_d1  = mm_t - mm_n1;
    assign mm_d2  = mm_t - mm_n2;
    assign mm_sel = (mm_t >= mm_n2) ? mm_d2 : ((mm_t >= mm_n1) ? mm_d1 : mm_t);
    assign mm_val = mm_sel[W-1:0];

    assign x_is_one = (x_reg == W'(1));
    assign x_is_nm1 = (x_reg == nm1_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_WIDTH - VERDICT_WIDTH){1'b0}}, m_verdict_reg};

    // Sequencer and datapath next state
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_verdict_next = m_verdict_reg;
        verdict_next   = verdict_reg;
        cnt_next       = cnt_reg;
        s_next         = s_reg;
        exp_cnt_next   = exp_cnt_reg;
        sq_cnt_next    = sq_cnt_reg;
        tz_seen_next   = tz_seen_reg;
        one_next       = one_reg;
        n_next         = n_reg;
        nm1_next       = nm1_reg;
        w_sr_next      = w_sr_reg;
        rem_next       = rem_reg;
        tz_sr_next     = tz_sr_reg;
        exp_sr_next    = exp_sr_reg;
        x_next         = x_reg;
        mm_a_next      = mm_a_reg;
        mm_b_next      = mm_b_reg;
        mm_acc_next    = mm_acc_reg;

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next     = s_tdata[W-1:0];
                    w_sr_next  = s_tdata[CAND_WIDTH+W-1:CAND_WIDTH];
                    state_next = ST_CLASS;
                end
            end

            // small-case rules
            ST_CLASS: begin
                nm1_next     = n_reg - W'(1);
                tz_sr_next   = n_reg - W'(1);
                rem_next     = '0;
                cnt_next     = W_C;
                s_next       = '0;
                tz_seen_next = 1'b0;
                if (n_reg[W-1:2] == '0 && n_reg[1]) begin
                    verdict_next = VERDICT_PRIME;
                    state_next   = ST_FIN;
                end else if (n_reg[W-1:1] == '0 || !n_reg[0]) begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = ST_FIN;
                end else begin
                    state_next = ST_PREP;
                end
            end

            // witness mod n, trailing-zero count of n-1
            ST_PREP: begin
                rem_next   = red_val;
                w_sr_next  = {w_sr_reg[W-2:0], 1'b0};
                tz_sr_next = {1'b0, tz_sr_reg[W-1:1]};
                if (!tz_seen_reg) begin
                    if (tz_sr_reg[0]) begin
                        tz_seen_next = 1'b1;
                    end else begin
                        s_next = s_reg + ONE_C;
                    end
                end
                cnt_next = cnt_reg - ONE_C;
                if (cnt_reg == ONE_C) begin
                    state_next = ST_BASE;
                end
            end

            // trivial bases pass
            ST_BASE: begin
                if (rem_reg == '0 || rem_reg == W'(1) || rem_reg == nm1_reg) begin
                    verdict_next = VERDICT_PROBABLE;
                    state_next   = ST_FIN;
                end else begin
                    x_next       = W'(1);
                    one_next     = 1'b1;
                    exp_sr_next  = nm1_reg;
                    exp_cnt_next = W_C - s_reg;
                    state_next   = ST_ESQ;
                end
            end

            // exponent bit: square
            ST_ESQ: begin
                if (exp_cnt_reg == '0) begin
                    state_next = ST_XCHK;
                end else if (one_reg) begin
                    state_next = ST_EMUL;
                end else begin
                    mm_a_next   = x_reg;
                    mm_b_next   = x_reg;
                    mm_acc_next = '0;
                    cnt_next    = W_C;
                    ret_next    = ST_EMUL;
                    state_next  = ST_MUL;
                end
            end

            // exponent bit: multiply by base when set
            ST_EMUL: begin
                if (exp_sr_reg[W-1]) begin
                    if (one_reg) begin
                        x_next     = rem_reg;
                        one_next   = 1'b0;
                        state_next = ST_ENEXT;
                    end else begin
                        mm_a_next   = x_reg;
                        mm_b_next   = rem_reg;
                        mm_acc_next = '0;
                        cnt_next    = W_C;
                        ret_next    = ST_ENEXT;
                        state_next  = ST_MUL;
                    end
                end else begin
                    state_next = ST_ENEXT;
                end
            end

            ST_ENEXT: begin
                exp_sr_next  = {exp_sr_reg[W-2:0], 1'b0};
                exp_cnt_next = exp_cnt_reg - ONE_C;
                state_next   = ST_ESQ;
            end

            // x = base^r checked
            ST_XCHK: begin
                if (x_is_one || x_is_nm1) begin
                    verdict_next = VERDICT_PROBABLE;
                    state_next   = ST_FIN;
                end else begin
                    sq_cnt_next = s_reg - ONE_C;
                    state_next  = ST_SQ;
                end
            end

            // repeated squaring
            ST_SQ: begin
                if (sq_cnt_reg == '0) begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = ST_FIN;
                end else begin
                    sq_cnt_next = sq_cnt_reg - ONE_C;
                    mm_a_next   = x_reg;
                    mm_b_next   = x_reg;
                    mm_acc_next = '0;
                    cnt_next    = W_C;
                    ret_next    = ST_SCHK;
                    state_next  = ST_MUL;
                end
            end

            ST_SCHK: begin
                if (x_is_one) begin
                    verdict_next = VERDICT_COMPOSITE;
                    state_next   = ST_FIN;
                end else if (x_is_nm1) begin
                    verdict_next = VERDICT_PROBABLE;
                    state_next   = ST_FIN;
                end else begin
                    state_next = ST_SQ;
                end
            end

            // shared multiply-reduce, one multiplier bit per cycle
            ST_MUL: begin
                mm_acc_next = mm_val;
                mm_b_next   = {mm_b_reg[W-2:0], 1'b0};
                cnt_next    = cnt_reg - ONE_C;
                if (cnt_reg == ONE_C) begin
                    x_next     = mm_val;
                    state_next = ret_reg;
                end
            end

            // hand the verdict to the output register
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    m_verdict_next = verdict_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        m_verdict_reg <= m_verdict_next;
        verdict_reg   <= verdict_next;
        cnt_reg       <= cnt_next;
        s_reg         <= s_next;
        exp_cnt_reg   <= exp_cnt_next;
        sq_cnt_reg    <= sq_cnt_next;
        tz_seen_reg   <= tz_seen_next;
        one_reg       <= one_next;
        n_reg         <= n_next;
        nm1_reg       <= nm1_next;
        w_sr_reg      <= w_sr_next;
        rem_reg       <= rem_next;
        tz_sr_reg     <= tz_sr_next;
        exp_sr_reg    <= exp_sr_next;
        x_reg         <= x_next;
        mm_a_reg      <= mm_a_next;
        mm_b_reg      <= mm_b_next;
        mm_acc_reg    <= mm_acc_next;
    end

endmodule

// File: tb/sv/mrw_verdict_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts one verdict per accepted item and compares
// every returned item against the oldest prediction still owed.
module mrw_verdict_checker
    import mrw_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    // s_tdata: [63:0] candidate, [127:64] witness
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // m_tdata: [1:0] verdict, [7:2] zero
    input  logic [M_TDATA_WIDTH-1:0] m_tdata,
    output int unsigned              mismatch_count,
    output int unsigned              verdicts_owed
);

    typedef logic [CAND_WIDTH-1:0] num_t;

    logic [VERDICT_WIDTH-1:0] verdict_q[$];
    logic [VERDICT_WIDTH-1:0] oldest_verdict;
    logic [M_TDATA_WIDTH-1:0] want_tdata;
    int unsigned              verdict_idx;

    // exact (a * b) mod n through the full double-width product
    function automatic num_t mulmod(input num_t a, input num_t b, input num_t n);
        logic [2*CAND_WIDTH-1:0] prod;
        prod = {{CAND_WIDTH{1'b0}}, a} * {{CAND_WIDTH{1'b0}}, b};
        prod = prod % {{CAND_WIDTH{1'b0}}, n};
        return prod[CAND_WIDTH-1:0];
    endfunction

    // base^e mod n, right-to-left square-and-multiply
    function automatic num_t powmod(input num_t base, input num_t e, input num_t n);
        num_t acc;
        acc = 1;
        while (e != 0) begin
            if (e[0])
                acc = mulmod(acc, base, n);
            e = e >> 1;
            base = mulmod(base, base, n);
        end
        return acc;
    endfunction

    // one witness round of the strong probable-prime test
    function automatic logic [VERDICT_WIDTH-1:0] predict_verdict(input num_t n, input num_t w);
        num_t nm1;
        num_t odd_part;
        num_t base;
        num_t x;
        int   twos;
        if (n == 2 || n == 3)
            return VERDICT_PRIME;
        if (n <= 1 || !n[0])
            return VERDICT_COMPOSITE;
        nm1 = n - 1;
        odd_part = nm1;
        twos = 0;
        while (!odd_part[0]) begin
            odd_part = odd_part >> 1;
            twos++;
        end
        base = w % n;
        // trivial bases always pass
        if (base == 0 || base == 1 || base == nm1)
            return VERDICT_PROBABLE;
        x = powmod(base, odd_part, n);
        if (x == 1 || x == nm1)
            return VERDICT_PROBABLE;
        for (int j = 1; j < twos; j++) begin
            x = mulmod(x, x, n);
            if (x == 1)
                return VERDICT_COMPOSITE;
            if (x == nm1)
                return VERDICT_PROBABLE;
        end
        return VERDICT_COMPOSITE;
    endfunction

    // predict on input accept, compare on output accept
    always @(posedge aclk) begin
        if (!aresetn) begin
            verdict_q.delete();
            mismatch_count <= 0;
            verdicts_owed  <= 0;
            verdict_idx    <= 0;
        end else begin
            if (s_tvalid && s_tready)
                verdict_q.push_back(predict_verdict(s_tdata[CAND_WIDTH-1:0],
                                                    s_tdata[2*CAND_WIDTH-1:CAND_WIDTH]));
            if (m_tvalid && m_tready) begin
                verdict_idx <= verdict_idx + 1;
                if (verdict_q.size() == 0) begin
                    $display("%0t: verdict item %0d with nothing expected, got 0x%02h",
                             $time, verdict_idx, m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    oldest_verdict = verdict_q.pop_front();
                    want_tdata = '0;
                    want_tdata[VERDICT_WIDTH-1:0] = oldest_verdict;
                    if (m_tdata !== want_tdata) begin
                        $display("%0t: verdict item %0d mismatch, expected 0x%02h got 0x%02h",
                                 $time, verdict_idx, want_tdata, m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            verdicts_owed <= verdict_q.size();
        end
    end

endmodule

// File: tb/sv/miller_rabin_witness_round_tb.sv
`timescale 1ns / 1ps

module miller_rabin_witness_round_tb
    import mrw_pkg::*;
();

    // longest stretch with no accept on either side before giving up
    localparam int unsigned QUIET_LIMIT = 60000;
    localparam int unsigned ITEMS_PER_PHASE = 382;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_WIDTH-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    int unsigned mismatch_count;
    int unsigned verdicts_owed;
    int unsigned quiet_cycles = 0;
    int unsigned src_idle_pct = 17;
    int unsigned sink_idle_pct = 86;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    miller_rabin_witness_round u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mrw_verdict_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .verdicts_owed  (verdicts_owed)
    );

    // verdict receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // watchdog on accepts
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // known primes and pseudoprimes, some with long squaring chains
    function automatic logic [63:0] deep_candidate(input int unsigned idx);
        case (idx)
            0:       return 64'd65537;
            1:       return 64'd998244353;
            2:       return 64'd2147483647;
            3:       return 64'd4294967291;
            4:       return 64'hFFFF_FFFF_0000_0001;
            5:       return 64'h1FFF_FFFF_FFFF_FFFF;
            6:       return 64'hFFFF_FFFF_FFFF_FFC5;
            7:       return 64'd2047;
            8:       return 64'd3215031751;
            9:       return 64'd3825123056546413051;
            10:      return 64'd1000000007;
            default: return 64'd561;
        endcase
    endfunction

    // one item: random gap, then hold valid until accepted
    task automatic send_item(input logic [63:0] cand, input logic [63:0] wit);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wit, cand};
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every verdict is back
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_owed != 0)
            @(posedge aclk);
    endtask

    task automatic send_random_item();
        logic [63:0] cand;
        logic [63:0] wit;
        int unsigned pick;
        int unsigned offs;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // tiny candidates: zero, one, two, three
            cand = 64'($urandom_range(0, 3));
            wit  = rand64();
        end else if (pick < 22) begin
            // even candidates of any size
            cand = rand64() >> $urandom_range(0, 62);
            cand[0] = 1'b0;
            wit  = rand64();
        end else if (pick < 32) begin
            // base that reduces to 0, 1 or n-1
            cand = (rand64() >> $urandom_range(0, 60)) | 64'd5;
            offs = $urandom_range(0, 2);
            wit  = cand * 64'($urandom_range(0, 3));
            if (offs == 1)
                wit = wit + 1;
            else if (offs == 2)
                wit = wit + cand - 1;
        end else if (pick < 58) begin
            // small odd candidates, full witness
            cand = (rand64() >> $urandom_range(44, 61)) | 64'd1;
            wit  = rand64();
        end else if (pick < 80) begin
            cand = deep_candidate($urandom_range(0, 11));
            if ($urandom_range(0, 1))
                wit = 64'($urandom_range(2, 40));
            else
                wit = rand64();
        end else begin
            cand = (rand64() >> $urandom_range(0, 40)) | 64'd1;
            wit  = rand64() >> $urandom_range(0, 63);
        end
        send_item(cand, wit);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: small-case rules, trivial bases, known primes and pseudoprimes
        send_item(64'd0, 64'd7);
        send_item(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'd3, 64'd0);
        send_item(64'd4, 64'd3);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 64'd5);
        send_item(64'd5, 64'd2);
        send_item(64'd97, 64'd0);
        send_item(64'd97, 64'd1);
        send_item(64'd97, 64'd96);
        send_item(64'd97, 64'd98);
        send_item(64'd97, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'd2);
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4);
        send_item(64'd2047, 64'd2);
        send_item(64'd2047, 64'd3);
        send_item(64'd561, 64'd2);
        send_item(64'd3825123056546413051, 64'd7);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
        send_item(64'h8000_0000_0000_0001, 64'd5);
        send_item(64'd65537, 64'd3);
        send_item(64'hFFFF_FFFF_0000_0001, 64'h5555_5555_AAAA_AAAA);
        drain_verdicts();

        // random phases: slow receiver, slow sender, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                src_idle_pct  <= 86;
                sink_idle_pct <= 17;
            end else if (phase == 2) begin
                src_idle_pct  <= 0;
                sink_idle_pct <= 0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_item();
            drain_verdicts();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && verdicts_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mrw_pkg.sv
hw/rtl/miller_rabin_witness_round.sv
tb/sv/mrw_verdict_checker.sv
tb/sv/miller_rabin_witness_round_tb.sv
